// ----- design/udpx_pkg.sv -----
// Package for the UDP payload extractor.
// Holds protocol constants, register indexes and the structs passed between modules.
`timescale 1ns / 1ps

package udpx_pkg;

  localparam int unsigned ETH_HDR_BYTES = 14;
  localparam int unsigned UDP_HDR_BYTES = 8;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [3:0]  IHL_MIN = 4'd5;

  localparam logic [15:0] POS_ETYPE_HI = 16'd12;
  localparam logic [15:0] POS_ETYPE_LO = 16'd13;
  localparam logic [15:0] POS_IHL = 16'd14;
  localparam logic [15:0] POS_PROTO = 16'd23;
  localparam logic [15:0] POS_MAX = 16'hFFFF;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic REG_SKIP_ENABLE = 1'b0;
  localparam logic REG_SKIP_LENGTH = 1'b1;

  localparam logic       SKIP_ENABLE_RST = 1'b1;
  localparam logic [7:0] SKIP_LENGTH_RST = 8'd10;

  typedef struct packed {
    logic       skip_enable;
    logic [7:0] skip_length;
  } udpx_cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } udpx_beat_t;

endpackage

// ----- design/udp_payload_extractor.sv -----
// UDP payload extractor for captured Ethernet frames, byte-wide stream in and out.
// Depends on udpx_pkg, udpx_cfg_regs, udpx_parser and udpx_out_stage.
//
// Usage:
//   Input channel (in_*): one frame byte per beat in wire order. in_capture_length
//   is sampled on the first byte of a frame; in_frame_end marks the last byte.
//   Output channel (out_*): payload bytes of accepted UDP frames; out_payload_last
//   marks the final payload byte. Frames that are not IPv4/UDP, have IHL below 5,
//   a zero payload or a payload past the capture length emit nothing.
//   Config port (cfg_*): skip_enable at 0x0, skip_length at 0x4; writes take
//   effect on the next byte.
//   Timing: a payload byte appears on out_* in the cycle after its input beat.
//   Throughput: one byte per cycle while no beat is held by out_stall, set by the single output register.
//   Stall: while out_stall holds a pending beat, in_stall is raised and the
//   parser holds its state; the pending beat stays unchanged.
//   Reset: rst_n (synchronous) empties the output register, restarts the frame
//   at byte zero and restores skip_enable = 1, skip_length = 10.
`timescale 1ns / 1ps

module udp_payload_extractor
  import udpx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_frame_byte,
  input  logic [15:0]           in_capture_length,
  input  logic                  in_frame_end,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_payload_byte,
  output logic                  out_payload_last,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  udpx_cfg_t  cfg;
  udpx_beat_t res;
  logic       busy;
  logic       adv;

  assign in_stall = busy;
  assign adv      = in_valid & !busy;

  udpx_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  udpx_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .frame_byte     (in_frame_byte),
    .capture_length (in_capture_length),
    .frame_end      (in_frame_end),
    .cfg            (cfg),
    .res            (res)
  );

  udpx_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res              (res),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_payload_last (out_payload_last)
  );

endmodule

// ----- design/udpx_cfg_regs.sv -----
// APB-style configuration registers of the UDP payload extractor.
// Depends on udpx_pkg for register indexes and the config struct.
`timescale 1ns / 1ps

module udpx_cfg_regs
  import udpx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output udpx_cfg_t             cfg
);

  logic       skip_enable_r;
  logic [7:0] skip_length_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_enable_r <= SKIP_ENABLE_RST;
      skip_length_r <= SKIP_LENGTH_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_SKIP_ENABLE: skip_enable_r <= pwdata[0];
        REG_SKIP_LENGTH: skip_length_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_SKIP_ENABLE: prdata = {31'd0, skip_enable_r};
      REG_SKIP_LENGTH: prdata = {24'd0, skip_length_r};
      default: prdata = '0;
    endcase
  end

  assign cfg.skip_enable = skip_enable_r;
  assign cfg.skip_length = skip_length_r;

endmodule

// ----- design/udpx_parser.sv -----
// Header parser: tracks byte position, checks Ethernet/IPv4/UDP fields, picks payload.
// Depends on udpx_pkg for constants and the beat and config structs.
`timescale 1ns / 1ps

module udpx_parser
  import udpx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic [7:0] frame_byte,
  input  logic [15:0] capture_length,
  input  logic       frame_end,
  input  udpx_cfg_t  cfg,
  output udpx_beat_t res
);

  logic [15:0] pos_r, pos_nxt;
  logic [15:0] cap_r, cap_nxt;
  logic [15:0] etype_r, etype_nxt;
  logic [5:0]  ihb_r, ihb_nxt;
  logic [15:0] udp_len_r, udp_len_nxt;
  logic        drop_r, drop_nxt;
  logic [16:0] stop_r, stop_nxt;
  logic        stop_ok_r;

  logic        pos0;
  logic [15:0] etype_cur;
  logic        drop_cur;
  logic [6:0]  ihb_new;
  logic [6:0]  l4_base;
  logic [15:0] l4_base16;
  logic [7:0]  skip;
  logic [15:0] offset;
  logic [16:0] pos_p1;
  logic        len_nz;
  logic        emit;

  assign pos0 = (pos_r == '0);
  assign skip = cfg.skip_enable ? cfg.skip_length : 8'd0;

  always_comb begin
    cap_nxt   = pos0 ? capture_length : cap_r;
    etype_cur = pos0 ? 16'd0 : etype_r;
    drop_cur  = pos0 ? 1'b0 : drop_r;
    ihb_nxt   = pos0 ? 6'd0 : ihb_r;
    ihb_new   = {1'b0, frame_byte[3:0], 2'b00};

    etype_nxt = etype_cur;
    if (pos_r == POS_ETYPE_HI || pos_r == POS_ETYPE_LO) begin
      etype_nxt = {etype_cur[7:0], frame_byte};
    end

    drop_nxt = drop_cur;
    if (pos_r == POS_ETYPE_LO && etype_nxt != ETHERTYPE_IPV4) begin
      drop_nxt = 1'b1;
    end
    if (pos_r == POS_IHL) begin
      ihb_nxt = ihb_new[5:0];
      if (frame_byte[3:0] < IHL_MIN ||
          cap_nxt < 16'(ihb_new + 7'(ETH_HDR_BYTES + UDP_HDR_BYTES))) begin
        drop_nxt = 1'b1;
      end
    end
    if (pos_r == POS_PROTO && frame_byte != PROTO_UDP) begin
      drop_nxt = 1'b1;
    end
  end

  assign l4_base   = 7'(ETH_HDR_BYTES) + {1'b0, ihb_r};
  assign l4_base16 = {9'd0, l4_base};

  always_comb begin
    udp_len_nxt = pos0 ? 16'd0 : udp_len_r;
    if (pos_r > POS_IHL && !drop_nxt &&
        (pos_r == l4_base16 + 16'd4 || pos_r == l4_base16 + 16'd5)) begin
      udp_len_nxt = {udp_len_r[7:0], frame_byte};
    end
  end

  assign stop_nxt = 17'(ETH_HDR_BYTES) + {11'd0, ihb_r} + {1'b0, udp_len_r};
  assign offset   = l4_base16 + 16'(UDP_HDR_BYTES) + {8'd0, skip};
  assign pos_p1   = {1'b0, pos_r} + 17'd1;
  assign len_nz   = udp_len_r > (16'(UDP_HDR_BYTES) + {8'd0, skip});
  assign emit     = !drop_r && pos_r > POS_IHL && pos_r >= offset &&
                    pos_p1 <= stop_r && len_nz && stop_ok_r;

  always_comb begin
    if (frame_end) begin
      pos_nxt = '0;
    end else if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + 16'd1;
    end else begin
      pos_nxt = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      drop_r <= 1'b0;
    end else if (adv) begin
      pos_r  <= pos_nxt;
      drop_r <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cap_r     <= cap_nxt;
      etype_r   <= etype_nxt;
      ihb_r     <= ihb_nxt;
      udp_len_r <= udp_len_nxt;
      stop_r    <= stop_nxt;
      stop_ok_r <= (stop_r <= {1'b0, cap_r});
    end
  end

  assign res.valid = adv & emit;
  assign res.data  = frame_byte;
  assign res.last  = (pos_p1 == stop_r);

  property p_emit_past_header;
    @(posedge clk) disable iff (!rst_n)
      res.valid |-> (pos_r >= 16'(ETH_HDR_BYTES + UDP_HDR_BYTES + 20));
  endproperty
  a_emit_past_header: assert property (p_emit_past_header)
    else $error("payload beat emitted inside the headers");

  property p_new_frame_clears_drop;
    @(posedge clk) disable iff (!rst_n)
      (adv && pos0) |=> !drop_r;
  endproperty
  a_new_frame_clears_drop: assert property (p_new_frame_clears_drop)
    else $error("drop flag survived the first byte of a frame");

  property p_bad_etype_drops;
    @(posedge clk) disable iff (!rst_n)
      (adv && pos_r == POS_ETYPE_LO && etype_nxt != ETHERTYPE_IPV4) |=> drop_r;
  endproperty
  a_bad_etype_drops: assert property (p_bad_etype_drops)
    else $error("non-IPv4 frame not dropped");

endmodule

// ----- design/udpx_out_stage.sv -----
// Output register of the UDP payload extractor; holds a beat while the receiver stalls.
// Depends on udpx_pkg for the beat struct.
`timescale 1ns / 1ps

module udpx_out_stage
  import udpx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  udpx_beat_t res,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_payload_last
);

  logic       valid_r;
  logic [7:0] data_r;
  logic       last_r;
  logic       load;

  assign busy = valid_r & out_stall;
  assign load = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      data_r <= res.data;
      last_r <= res.last;
    end
  end

  assign out_valid        = valid_r;
  assign out_payload_byte = data_r;
  assign out_payload_last = last_r;

endmodule

// ----- dv/tb_udp_payload_extractor.sv -----
// Self-checking testbench for udp_payload_extractor: byte-wide frames in, UDP payload out.
// Depends on udpx_pkg and the extractor RTL; predicts every payload beat in-line.
`timescale 1ns / 1ps

module tb;
  import udpx_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam logic [7:0] PROTO_TCP = 8'd6;

  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] cap;
    logic        fend;
  } wire_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } payload_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_frame_byte = '0;
  logic [15:0] in_capture_length = '0;
  logic        in_frame_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_payload_byte;
  logic        out_payload_last;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  udp_payload_extractor dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_frame_byte(in_frame_byte),
    .in_capture_length(in_capture_length),
    .in_frame_end(in_frame_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_payload_byte(out_payload_byte),
    .out_payload_last(out_payload_last),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  wire_byte_t frame_byte_q[$];
  payload_t   payload_expect_q[$];
  wire_byte_t next_beat;
  payload_t   predicted;
  payload_t   seen;

  int  beats_loaded = 0;
  int  beats_taken = 0;
  int  error_count = 0;
  int  cycle_count = 0;
  int  hold_count = 0;
  int  send_idle_pct = 33;
  int  recv_idle_pct = 87;
  bit  pressure_armed = 1'b0;
  bit  in_beat_taken = 1'b0;

  logic       skip_on = SKIP_ENABLE_RST;
  logic [7:0] skip_len = SKIP_LENGTH_RST;

  logic [15:0] frame_pos = '0;
  logic [15:0] held_cap = '0;
  logic [15:0] etype_seen = '0;
  logic [5:0]  ip_hdr_bytes = '0;
  logic [15:0] udp_len_seen = '0;
  logic        frame_bad = 1'b0;

  function automatic int active_skip();
    return skip_on ? int'(skip_len) : 0;
  endfunction

  function automatic bit parse_frame_byte(input logic [7:0] b, input logic [15:0] cap,
                                          input logic fend, output payload_t res);
    int unsigned pos, l4_base, skip, offset, plen, stop;
    bit hit;
    pos = frame_pos;
    hit = 1'b0;
    res = '0;
    if (pos == 0) begin
      held_cap = cap;
      etype_seen = '0;
      ip_hdr_bytes = '0;
      udp_len_seen = '0;
      frame_bad = 1'b0;
    end
    if (pos == POS_ETYPE_HI || pos == POS_ETYPE_LO) etype_seen = {etype_seen[7:0], b};
    if (pos == POS_ETYPE_LO && etype_seen != ETHERTYPE_IPV4) frame_bad = 1'b1;
    if (pos == POS_IHL) begin
      ip_hdr_bytes = {b[3:0], 2'b00};
      if (b[3:0] < IHL_MIN) frame_bad = 1'b1;
      else if (held_cap < ETH_HDR_BYTES + ip_hdr_bytes + UDP_HDR_BYTES) frame_bad = 1'b1;
    end
    if (pos == POS_PROTO && b != PROTO_UDP) frame_bad = 1'b1;
    if (pos > ETH_HDR_BYTES && !frame_bad) begin
      l4_base = ETH_HDR_BYTES + ip_hdr_bytes;
      skip = active_skip();
      if (pos == l4_base + 4 || pos == l4_base + 5) begin
        udp_len_seen = {udp_len_seen[7:0], b};
      end else if (pos >= l4_base + UDP_HDR_BYTES) begin
        offset = l4_base + UDP_HDR_BYTES + skip;
        plen = (udp_len_seen > UDP_HDR_BYTES + skip) ? udp_len_seen - UDP_HDR_BYTES - skip : 0;
        stop = offset + plen;
        if (plen != 0 && stop <= held_cap && pos >= offset && pos < stop) begin
          res.data = b;
          res.last = (pos == stop - 1);
          hit = 1'b1;
        end
      end
    end
    if (fend) frame_pos = '0;
    else if (frame_pos != POS_MAX) frame_pos = frame_pos + 16'd1;
    return hit;
  endfunction

  task automatic load_frame(input logic [15:0] etype, input logic [3:0] ihl,
                            input logic [7:0] proto, input logic [15:0] udp_len,
                            input int total, input logic [15:0] cap);
    int l4_base;
    wire_byte_t wb;
    l4_base = ETH_HDR_BYTES + 4 * ihl;
    for (int i = 0; i < total; i++) begin
      wb.data = 8'($urandom);
      if (i == POS_ETYPE_HI) wb.data = etype[15:8];
      if (i == POS_ETYPE_LO) wb.data = etype[7:0];
      if (i == POS_IHL) wb.data = {4'($urandom), ihl};
      if (i == POS_PROTO) wb.data = proto;
      if (ihl >= IHL_MIN && i == l4_base + 4) wb.data = udp_len[15:8];
      if (ihl >= IHL_MIN && i == l4_base + 5) wb.data = udp_len[7:0];
      wb.cap = (i == 0) ? cap : 16'($urandom);
      wb.fend = (i == total - 1);
      frame_byte_q.push_back(wb);
      beats_loaded++;
    end
  endtask

  // capture and frame length are given relative to the payload end
  task automatic load_udp_frame(input logic [3:0] ihl, input int plen, input int cap_delta,
                                input int end_delta);
    int stop;
    stop = ETH_HDR_BYTES + 4 * ihl + UDP_HDR_BYTES + active_skip() + plen;
    load_frame(ETHERTYPE_IPV4, ihl, PROTO_UDP, 16'(UDP_HDR_BYTES + active_skip() + plen),
               stop + end_delta, 16'(stop + cap_delta));
  endtask

  task automatic load_random_frame();
    int pick, plen, r, skip, full_len;
    logic [3:0] ihl;
    skip = active_skip();
    pick = $urandom_range(99);
    ihl = ($urandom_range(3) == 0) ? 4'($urandom_range(5, 15)) : IHL_MIN;
    plen = $urandom_range(2, 48);
    full_len = ETH_HDR_BYTES + 20 + UDP_HDR_BYTES + skip + plen;
    if (pick < 65) begin
      r = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0;
      load_udp_frame(ihl, plen, r, r + (($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0));
    end else if (pick < 70) begin
      r = $urandom_range(1, plen - 1);
      load_udp_frame(ihl, plen, 0, -r);
    end else if (pick < 75) begin
      r = $urandom_range(1, plen);
      load_udp_frame(ihl, plen, -r, 0);
    end else if (pick < 79) begin
      r = $urandom_range(1, ETH_HDR_BYTES + 4 * ihl + UDP_HDR_BYTES);
      load_udp_frame(ihl, plen, -(skip + plen + r), 0);
    end else if (pick < 83) begin
      r = $urandom_range(0, UDP_HDR_BYTES + skip);
      load_udp_frame(ihl, -r, 0, r + $urandom_range(0, 8));
    end else if (pick < 87) begin
      load_frame(ETHERTYPE_IPV4 ^ 16'($urandom_range(1, 16'hFFFF)), IHL_MIN, PROTO_UDP,
                 16'(full_len - 34), full_len, 16'(full_len));
    end else if (pick < 91) begin
      load_frame(ETHERTYPE_IPV4, 4'($urandom_range(0, 4)), PROTO_UDP,
                 16'(full_len - 34), full_len, 16'(full_len));
    end else if (pick < 95) begin
      load_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_UDP ^ 8'($urandom_range(1, 255)),
                 16'(full_len - 34), full_len, 16'(full_len));
    end else begin
      load_frame(16'($urandom), 4'($urandom), 8'($urandom), 16'($urandom),
                 $urandom_range(1, 64), 16'($urandom));
    end
  endtask

  task automatic run_random(input int target);
    int start;
    start = beats_loaded;
    while (beats_loaded - start < target) load_random_frame();
  endtask

  task automatic settle();
    while (beats_taken != beats_loaded || payload_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_ADDR_W'(4 * idx);
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_SKIP_ENABLE) skip_on = value[0];
    else skip_len = value[7:0];
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // driver: advance to the next byte only once the current beat is taken
  always @(negedge clk) begin
    if (!in_valid || in_beat_taken) begin
      if (frame_byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_beat = frame_byte_q.pop_front();
        in_valid <= 1'b1;
        in_frame_byte <= next_beat.data;
        in_capture_length <= next_beat.cap;
        in_frame_end <= next_beat.fend;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: hold off once for a long stretch, else stall at random
  always @(negedge clk) begin
    if (pressure_armed && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    in_beat_taken = rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (payload_expect_q.size() == 0) begin
        $error("unexpected payload beat: payload_byte %02h payload_last %0b",
               out_payload_byte, out_payload_last);
        error_count++;
      end else begin
        seen = payload_expect_q.pop_front();
        if (out_payload_byte !== seen.data) begin
          $error("payload_byte mismatch: expected %02h, actual %02h", seen.data,
                 out_payload_byte);
          error_count++;
        end
        if (out_payload_last !== seen.last) begin
          $error("payload_last mismatch: expected %0b, actual %0b", seen.last,
                 out_payload_last);
          error_count++;
        end
      end
    end
    if (in_beat_taken) begin
      beats_taken++;
      if (parse_frame_byte(in_frame_byte, in_capture_length, in_frame_end, predicted))
        payload_expect_q.push_back(predicted);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    load_udp_frame(IHL_MIN, 1, 0, 0);
    load_udp_frame(4'd15, 4, 0, 0);
    load_udp_frame(IHL_MIN, 6, 0, 3);
    load_udp_frame(IHL_MIN, 6, 5, 5);
    load_udp_frame(IHL_MIN, 8, 0, -3);
    load_udp_frame(IHL_MIN, 8, -1, 0);
    load_udp_frame(IHL_MIN, 0, 0, 4);
    load_udp_frame(IHL_MIN, -18, 0, 30);
    load_udp_frame(IHL_MIN, 4, -15, 0);
    load_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_UDP, 16'd30, 60, 16'd0);
    load_frame(16'h86DD, IHL_MIN, PROTO_UDP, 16'd30, 60, 16'd60);
    load_frame(ETHERTYPE_IPV4, 4'd4, PROTO_UDP, 16'd30, 60, 16'd60);
    load_frame(ETHERTYPE_IPV4, 4'd0, PROTO_UDP, 16'd30, 60, 16'd60);
    load_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, 16'd30, 60, 16'd60);
    load_frame(16'd0, 4'd0, 8'd0, 16'd0, 1, 16'hFFFF);
    load_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_UDP, 16'd21, 55, 16'hFFFF);
    load_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_UDP, 16'hFFFF, 70, 16'hFFFF);
    run_random(300);
    settle();

    send_idle_pct = 87;
    recv_idle_pct = 33;
    cfg_write(REG_SKIP_ENABLE, 32'd0);
    cfg_write(REG_SKIP_LENGTH, 32'd255);
    run_random(300);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_write(REG_SKIP_ENABLE, 32'd1);
    cfg_write(REG_SKIP_LENGTH, 32'd0);
    @(posedge clk);
    pressure_armed = 1'b1;
    run_random(150);
    settle();

    cfg_write(REG_SKIP_LENGTH, 32'd255);
    run_random(150);
    settle();

    cfg_write(REG_SKIP_LENGTH, 32'($urandom_range(1, 254)));
    run_random(150);
    settle();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
